// ----- rtl/core/arpc_pkg.sv -----
// Package for the ARP responder with aging cache.
// Holds the opcode, status and state codes and protocol constants; no dependencies.
`default_nettype none
package arpc_pkg;

	typedef enum logic [1:0] {
		OP_FRAME  = 2'd0,
		OP_TICK   = 2'd1,
		OP_REQ    = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_REFRESHED = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_DROPPED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TICK,
		S_FINISH,
		S_OUT
	} state_t;

	localparam logic [1:0]  OPC_REQUEST    = 2'd1;
	localparam logic [1:0]  OPC_REPLY      = 2'd2;
	localparam logic [15:0] ARP_OPC_REQ    = 16'd1;
	localparam logic [13:0] MIN_FRAME_LEN  = 14'd42;
	localparam logic [15:0] HW_ETHERNET    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN    = 8'h06;
	localparam logic [7:0]  PROTO_ADDR_LEN = 8'h04;
	localparam logic [7:0]  AGE_MAX        = 8'hff;
	localparam logic [47:0] MAC_BCAST      = 48'hffff_ffff_ffff;
	localparam logic [7:0]  AGING_RESET    = 8'd5;

	localparam logic [1:0] REG_OWN_IP  = 2'd0;
	localparam logic [1:0] REG_OWN_MAC = 2'd1;
	localparam logic [1:0] REG_AGING   = 2'd2;

	// Entry word as stored: ip, mac, age.
	localparam int ENTRY_W = 88;

endpackage
`default_nettype wire

// ----- rtl/core/arpc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  wire logic [WIDTH-1:0]                 wdata,
	output logic      [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/arp_responder_with_aging_cache.sv -----
// Top level of the ARP responder with an aging IP-to-MAC cache.
// Uses arpc_pkg and one arpc_ram instance for the entry store.
//
//  channel  | handshake          | contents
//  ---------+--------------------+---------------------------------------
//  input    | in_valid/in_ready  | op and parsed ARP header fields
//  output   | out_valid/out_ready| frame to send, cache status, lookup
//  config   | cfg_we             | own_ip, own_mac, aging_seconds
//
// A frame or lookup walks the cache one entry a cycle through the single RAM port and
// one shared IP comparator; a tick walks it through the same port, alternating reads
// and write-backs. A request command or a malformed frame does not walk the cache. The
// write-back of a frame happens in the finish state that ends its scan.
// Reset clears all valid bits at once. The input is not ready while a word is
// being worked on or its result still waits on a stalled output.
`default_nettype none
module arp_responder_with_aging_cache #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [13:0] frame_len,
	input  wire logic [15:0] hw_type,
	input  wire logic [15:0] proto_type,
	input  wire logic [7:0]  hw_len,
	input  wire logic [7:0]  proto_len,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] target_ip,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             frame_valid,
	output logic [1:0]       out_opcode,
	output logic [47:0]      dest_mac,
	output logic [47:0]      out_sender_mac,
	output logic [31:0]      out_sender_ip,
	output logic [47:0]      out_target_mac,
	output logic [31:0]      out_target_ip,
	output logic [2:0]       cache_status,
	output logic             lookup_hit,
	output logic [47:0]      lookup_mac,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);
	localparam int IW = $clog2(CACHE_ENTRIES > 1 ? CACHE_ENTRIES : 2);
	localparam int CW = IW + 1;

	arpc_pkg::state_t state_q, state_d;

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic [7:0]  aging_q;

	logic [CACHE_ENTRIES-1:0] valid_q;

	// Latched word.
	logic [1:0]  op_q;
	logic        bad_q;
	logic        to_us_q;
	logic        is_req_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q;
	logic [31:0] tip_q;

	// Scan bookkeeping: address counter, and a registered copy of the address that goes with the read data.
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rd_idx_q;
	logic          rd_ok_q;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [47:0]   hit_mac_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;

	// RAM port.
	logic                      ram_we;
	logic [IW-1:0]             ram_addr;
	logic [arpc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	arpc_ram #(.WIDTH(arpc_pkg::ENTRY_W), .DEPTH(CACHE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	logic [31:0] rd_ip;
	logic [47:0] rd_mac;
	logic [7:0]  rd_age;
	logic        cmp_eq;
	logic [31:0] key;
	logic [7:0]  new_age;

	assign rd_ip  = ram_rdata[87:56];
	assign rd_mac = ram_rdata[55:8];
	assign rd_age = ram_rdata[7:0];
	assign key    = (op_q == arpc_pkg::OP_LOOKUP) ? tip_q : sip_q;
	// The one shared comparator of the scan.
	assign cmp_eq = valid_q[rd_idx_q] && (rd_ip == key);
	assign new_age = (rd_age < arpc_pkg::AGE_MAX) ? rd_age + 8'd1 : rd_age;

	logic final_hit, final_free;
	logic [IW-1:0] final_hit_idx, final_free_idx;
	logic [47:0]   final_hit_mac;

	always_comb begin
		final_hit      = hit_q;
		final_hit_idx  = hit_idx_q;
		final_hit_mac  = hit_mac_q;
		final_free     = free_q;
		final_free_idx = free_idx_q;
		if (rd_ok_q && !hit_q && cmp_eq) begin
			final_hit     = 1'b1;
			final_hit_idx = rd_idx_q;
			final_hit_mac = rd_mac;
		end
		if (rd_ok_q && !free_q && !valid_q[rd_idx_q]) begin
			final_free     = 1'b1;
			final_free_idx = rd_idx_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = cnt_q[IW-1:0];
		ram_wdata = {sip_q, smac_q, 8'd0};
		in_ready  = 1'b0;
		unique case (state_q)
			arpc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op)
						arpc_pkg::OP_FRAME: begin
							if (frame_len < arpc_pkg::MIN_FRAME_LEN
								|| hw_type != arpc_pkg::HW_ETHERNET
								|| hw_len != arpc_pkg::HW_ADDR_LEN
								|| proto_type != arpc_pkg::PROTO_IPV4
								|| proto_len != arpc_pkg::PROTO_ADDR_LEN)
								state_d = arpc_pkg::S_OUT;
							else
								state_d = arpc_pkg::S_SCAN;
						end
						arpc_pkg::OP_TICK:   state_d = arpc_pkg::S_TICK;
						arpc_pkg::OP_REQ:    state_d = arpc_pkg::S_OUT;
						arpc_pkg::OP_LOOKUP: state_d = arpc_pkg::S_SCAN;
						default:             state_d = arpc_pkg::S_OUT;
					endcase
				end
			end
			arpc_pkg::S_SCAN: begin
				// Addresses issue until the last; the scan ends once the data of the last has been taken.
				if (!rd_ok_q && cnt_q == CW'(CACHE_ENTRIES)) begin
					state_d = arpc_pkg::S_FINISH;
				end
			end
			arpc_pkg::S_TICK: begin
				// Reads and write-backs alternate: the entry at cnt is read, and in the
				// following cycle the aged entry goes back to rd_idx.
				if (rd_ok_q) begin
					ram_we    = valid_q[rd_idx_q];
					ram_addr  = rd_idx_q;
					ram_wdata = {rd_ip, rd_mac, new_age};
				end
				if (!rd_ok_q && cnt_q == CW'(CACHE_ENTRIES)) begin
					state_d = arpc_pkg::S_OUT;
				end
			end
			arpc_pkg::S_FINISH: begin
				if (op_q == arpc_pkg::OP_FRAME) begin
					if (hit_q) begin
						ram_we    = 1'b1;
						ram_addr  = hit_idx_q;
					end else if (to_us_q && free_q) begin
						ram_we    = 1'b1;
						ram_addr  = free_idx_q;
					end
				end
				state_d = arpc_pkg::S_OUT;
			end
			arpc_pkg::S_OUT: begin
				if (out_ready) state_d = arpc_pkg::S_IDLE;
			end
			default: state_d = arpc_pkg::S_IDLE;
		endcase
	end

	assign out_valid = (state_q == arpc_pkg::S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= arpc_pkg::S_IDLE;
			own_ip_q <= '0;
			own_mac_q <= '0;
			aging_q  <= arpc_pkg::AGING_RESET;
			valid_q  <= '0;
			cnt_q    <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					arpc_pkg::REG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
					arpc_pkg::REG_OWN_MAC: own_mac_q <= cfg_data;
					arpc_pkg::REG_AGING:   aging_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			rd_ok_q <= 1'b0;
			if (state_q == arpc_pkg::S_IDLE) begin
				cnt_q <= '0;
			end else if ((state_q == arpc_pkg::S_SCAN
				|| (state_q == arpc_pkg::S_TICK && !rd_ok_q))
				&& cnt_q != CW'(CACHE_ENTRIES)) begin
				cnt_q   <= cnt_q + CW'(1);
				rd_ok_q <= 1'b1;
			end
			if (state_q == arpc_pkg::S_TICK && rd_ok_q && valid_q[rd_idx_q]
				&& new_age > aging_q)
				valid_q[rd_idx_q] <= 1'b0;
			if (state_q == arpc_pkg::S_FINISH && op_q == arpc_pkg::OP_FRAME
				&& !hit_q && to_us_q && free_q)
				valid_q[free_idx_q] <= 1'b1;
		end
	end

	// Payload and scan registers.
	always_ff @(posedge clk) begin
		rd_idx_q <= cnt_q[IW-1:0];
		if (state_q == arpc_pkg::S_IDLE && in_valid) begin
			op_q     <= op;
			bad_q    <= frame_len < arpc_pkg::MIN_FRAME_LEN
				|| hw_type != arpc_pkg::HW_ETHERNET || hw_len != arpc_pkg::HW_ADDR_LEN
				|| proto_type != arpc_pkg::PROTO_IPV4
				|| proto_len != arpc_pkg::PROTO_ADDR_LEN;
			to_us_q  <= (target_ip == own_ip_q);
			is_req_q <= (arp_opcode == arpc_pkg::ARP_OPC_REQ);
			smac_q   <= sender_mac;
			sip_q    <= sender_ip;
			tip_q    <= target_ip;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			hit_mac_q  <= '0;
		end else if (state_q == arpc_pkg::S_SCAN) begin
			hit_q      <= final_hit;
			hit_idx_q  <= final_hit_idx;
			hit_mac_q  <= final_hit_mac;
			free_q     <= final_free;
			free_idx_q <= final_free_idx;
		end
	end

	// Result fields from latched state.
	always_comb begin
		frame_valid    = 1'b0;
		out_opcode     = '0;
		dest_mac       = '0;
		out_sender_mac = '0;
		out_sender_ip  = '0;
		out_target_mac = '0;
		out_target_ip  = '0;
		cache_status   = arpc_pkg::ST_NONE;
		lookup_hit     = 1'b0;
		lookup_mac     = '0;
		case (op_q)
			arpc_pkg::OP_FRAME: begin
				if (bad_q) begin
					cache_status = arpc_pkg::ST_DROPPED;
				end else begin
					if (hit_q) cache_status = arpc_pkg::ST_REFRESHED;
					else if (to_us_q && free_q) cache_status = arpc_pkg::ST_INSERTED;
					else if (to_us_q) cache_status = arpc_pkg::ST_FULL;
					if (to_us_q && is_req_q) begin
						frame_valid    = 1'b1;
						out_opcode     = arpc_pkg::OPC_REPLY;
						dest_mac       = smac_q;
						out_sender_mac = own_mac_q;
						out_sender_ip  = own_ip_q;
						out_target_mac = smac_q;
						out_target_ip  = sip_q;
					end
				end
			end
			arpc_pkg::OP_REQ: begin
				frame_valid    = 1'b1;
				out_opcode     = arpc_pkg::OPC_REQUEST;
				dest_mac       = arpc_pkg::MAC_BCAST;
				out_sender_mac = own_mac_q;
				out_sender_ip  = sip_q;
				out_target_mac = arpc_pkg::MAC_BCAST;
				out_target_ip  = tip_q;
			end
			arpc_pkg::OP_LOOKUP: begin
				lookup_hit = hit_q;
				lookup_mac = hit_q ? hit_mac_q : '0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
